// File: hw/rtl/ird_pkg.sv
`default_nettype none
package ird_pkg;

    typedef enum logic [3:0] {
        ACT_GET        = 4'd0,
        ACT_PUT        = 4'd1,
        ACT_INSERT     = 4'd2,
        ACT_REMOVE     = 4'd3,
        ACT_ADD_LOW    = 4'd4,
        ACT_ADD_HIGH   = 4'd5,
        ACT_REMOVE_LOW = 4'd6,
        ACT_REMOVE_HIGH = 4'd7,
        ACT_ROTATE     = 4'd8
    } action_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [3:0]        action;
        logic signed [7:0] position;
        logic [31:0]       value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic [6:0]  fill_level;
        logic [1:0]  status;
    } out_item_t;

    // Datapath command from the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_START,
        CMD_READ,
        CMD_TAKE,
        CMD_PRIME,
        CMD_SHIFT,
        CMD_WRITE,
        CMD_COMMIT
    } cmd_t;

    // Datapath decode and progress back to the controller
    typedef struct packed {
        logic ok;
        logic do_write;
        logic do_read;
        logic grow;
        logic shrink;
        logic need_shift;
        logic last_move;
    } dp_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/ird_ctrl.sv
`default_nettype none
module ird_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire ird_pkg::dp_status_t st,
    output ird_pkg::cmd_t            cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_TAKE,
        S_PRIME,
        S_SHIFT,
        S_WRITE,
        S_COMMIT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Pick the next step and the command for the datapath
    always_comb
    begin
        state_next = state_reg;
        cmd = ird_pkg::CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd = ird_pkg::CMD_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd = ird_pkg::CMD_START;
                if (!st.ok)
                    state_next = S_COMMIT;
                else if (st.do_read)
                    state_next = S_READ;
                else if (st.grow)
                    state_next = st.need_shift ? S_PRIME : S_WRITE;
                else
                    state_next = S_COMMIT;
            end
            S_READ:
            begin
                cmd = ird_pkg::CMD_READ;
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                cmd = ird_pkg::CMD_TAKE;
                if (st.do_write)
                    state_next = S_WRITE;
                else if (st.shrink && st.need_shift)
                    state_next = S_PRIME;
                else
                    state_next = S_COMMIT;
            end
            S_PRIME:
            begin
                cmd = ird_pkg::CMD_PRIME;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd = ird_pkg::CMD_SHIFT;
                if (st.last_move)
                    state_next = st.grow ? S_WRITE : S_COMMIT;
            end
            S_WRITE:
            begin
                cmd = ird_pkg::CMD_WRITE;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd = ird_pkg::CMD_COMMIT;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// File: hw/rtl/ird_datapath.sv
`default_nettype none
module ird_datapath #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ird_pkg::in_item_t   in_item,
    input  wire ird_pkg::cmd_t       cmd,
    output ird_pkg::dp_status_t      st,
    output ird_pkg::out_item_t       out_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int PW = (CW + 2 > 9) ? CW + 2 : 9;
    localparam logic signed [PW-1:0] ONE_S = PW'(1);

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rd_reg;

    logic [AW-1:0]         head_reg;
    logic [CW-1:0]         count_reg;
    logic [3:0]            action_reg;
    logic signed [PW-1:0]  pos_reg;
    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] res_reg;
    logic [CW-1:0]         walk_reg;
    logic [1:0]            status_reg;
    logic [31:0]           out_word_reg;

    // Decode the held item
    logic signed [PW-1:0] len_s;
    logic is_get, is_put, is_ins, is_rem, is_addl, is_addh, is_reml, is_remh, is_rot;
    logic empty, full, grow, shrink;
    logic [1:0] dec_status;
    logic [CW-1:0] dec_idx;
    logic [CW-1:0] rot_idx;

    assign len_s   = PW'($signed({1'b0, count_reg}));
    assign is_get  = (action_reg == ird_pkg::ACT_GET);
    assign is_put  = (action_reg == ird_pkg::ACT_PUT);
    assign is_ins  = (action_reg == ird_pkg::ACT_INSERT);
    assign is_rem  = (action_reg == ird_pkg::ACT_REMOVE);
    assign is_addl = (action_reg == ird_pkg::ACT_ADD_LOW);
    assign is_addh = (action_reg == ird_pkg::ACT_ADD_HIGH);
    assign is_reml = (action_reg == ird_pkg::ACT_REMOVE_LOW);
    assign is_remh = (action_reg == ird_pkg::ACT_REMOVE_HIGH);
    assign is_rot  = (action_reg == ird_pkg::ACT_ROTATE);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign grow    = is_ins || is_addl || is_addh;
    assign shrink  = is_rem || is_reml || is_remh;

    // Count only changes at commit, so the decode holds for the whole item
    always_comb
    begin
        dec_status = ird_pkg::ST_OK;
        dec_idx = '0;
        rot_idx = '0;
        if (is_get || is_put)
        begin
            if (pos_reg < 0 || pos_reg >= len_s)
                dec_status = ird_pkg::ST_RANGE;
            dec_idx = CW'(pos_reg);
        end
        else if (is_ins)
        begin
            if (pos_reg < -len_s || pos_reg > len_s + ONE_S)
                dec_status = ird_pkg::ST_RANGE;
            else if (full)
                dec_status = ird_pkg::ST_FULL;
            dec_idx = (pos_reg >= ONE_S) ? CW'(pos_reg - ONE_S) : CW'(pos_reg + len_s);
        end
        else if (is_addl || is_addh)
        begin
            if (full)
                dec_status = ird_pkg::ST_FULL;
            dec_idx = is_addl ? '0 : count_reg;
        end
        else if (is_rem)
        begin
            if (empty)
                dec_status = ird_pkg::ST_EMPTY;
            else if (pos_reg < 0 || pos_reg >= len_s)
                dec_status = ird_pkg::ST_RANGE;
            dec_idx = CW'(pos_reg);
        end
        else if (is_reml || is_remh)
        begin
            if (empty)
                dec_status = ird_pkg::ST_EMPTY;
            dec_idx = is_reml ? '0 : count_reg - 1'b1;
        end
        else if (is_rot)
        begin
            if (!empty && (pos_reg < -len_s || pos_reg > len_s))
                dec_status = ird_pkg::ST_RANGE;
            // n mod L for 0..L is n, or 0 when n equals L
            if (pos_reg >= 0)
                rot_idx = (pos_reg == len_s) ? '0 : CW'(pos_reg);
            else
                rot_idx = CW'(pos_reg + len_s);
        end
    end

    assign st.ok         = (dec_status == ird_pkg::ST_OK);
    assign st.do_read    = is_get || is_put || shrink;
    assign st.do_write   = is_put;
    assign st.grow       = grow;
    assign st.shrink     = shrink;
    assign st.need_shift = grow ? (dec_idx != count_reg) : (dec_idx != count_reg - 1'b1);
    assign st.last_move  = grow ? (walk_reg == dec_idx + 1'b1)
                                : (walk_reg + CW'(2) == count_reg);

    // Physical slot of a logical index, k at most DEPTH
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(k);
        if (s >= SW'(DEPTH))
            s = s - SW'(DEPTH);
        return AW'(s);
    endfunction

    // Pick the read and write addresses for this cycle
    logic [CW-1:0]         rd_k;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;

    always_comb
    begin
        rd_k    = dec_idx;
        wr_en   = 1'b0;
        wr_addr = slot(head_reg, dec_idx);
        wr_data = word_reg;
        case (cmd)
            ird_pkg::CMD_PRIME:
            begin
                rd_k = grow ? walk_reg - 1'b1 : walk_reg + 1'b1;
            end
            ird_pkg::CMD_SHIFT:
            begin
                // Write the word read last cycle and fetch the next one
                if (grow)
                    rd_k = (walk_reg >= CW'(2)) ? walk_reg - CW'(2) : '0;
                else
                    rd_k = walk_reg + CW'(2);
                wr_en   = 1'b1;
                wr_addr = slot(head_reg, walk_reg);
                wr_data = rd_reg;
            end
            ird_pkg::CMD_WRITE:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign rd_addr = slot(head_reg, rd_k);

    // Memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    // Load, walk and commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            action_reg   <= '0;
            pos_reg      <= '0;
            word_reg     <= '0;
            res_reg      <= '0;
            walk_reg     <= '0;
            status_reg   <= ird_pkg::ST_OK;
            out_word_reg <= '0;
        end
        else
        begin
            unique case (cmd)
                ird_pkg::CMD_LOAD:
                begin
                    action_reg <= in_item.action;
                    pos_reg    <= PW'($signed(in_item.position));
                    word_reg   <= WORD_WIDTH'(in_item.value);
                end
                ird_pkg::CMD_START:
                begin
                    walk_reg <= grow ? count_reg : dec_idx;
                end
                ird_pkg::CMD_TAKE:
                begin
                    res_reg <= rd_reg;
                end
                ird_pkg::CMD_SHIFT:
                begin
                    walk_reg <= grow ? walk_reg - 1'b1 : walk_reg + 1'b1;
                end
                ird_pkg::CMD_COMMIT:
                begin
                    status_reg <= dec_status;
                    if (dec_status != ird_pkg::ST_OK)
                        out_word_reg <= '0;
                    else if (grow)
                        out_word_reg <= 32'(word_reg);
                    else if (is_get || is_put || shrink)
                        out_word_reg <= 32'(res_reg);
                    else
                        out_word_reg <= '0;
                    if (dec_status == ird_pkg::ST_OK)
                    begin
                        if (grow)
                            count_reg <= count_reg + 1'b1;
                        else if (shrink)
                        begin
                            count_reg <= count_reg - 1'b1;
                            if (count_reg == CW'(1))
                                head_reg <= '0;
                        end
                        else if (is_rot && !empty)
                            head_reg <= slot(head_reg, rot_idx);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_item.result_value = out_word_reg;
    assign out_item.fill_level   = 7'(count_reg);
    assign out_item.status       = status_reg;

endmodule
`default_nettype wire

// File: hw/rtl/indexed_ring_deque.sv
// Indexed ring deque: one result per item, one item in flight at a time.
// Each item runs through decode, then the read, shift and write steps its action needs, then commit.
// Get reads a word, put reads and writes one, insert and add write one; insert, add low,
// remove and remove low also shift the words between the index and the end of the ring.
// A new item is taken only after the result of the last one has been accepted.
// Reset empties the ring and zeroes the head; entry contents are left as they are.
`default_nettype none
module indexed_ring_deque #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ird_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ird_pkg::out_item_t      out_data
);

    ird_pkg::cmd_t       cmd;
    ird_pkg::dp_status_t st;

    ird_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    ird_datapath #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .cmd      (cmd),
        .st       (st),
        .out_item (out_data)
    );

endmodule
`default_nettype wire

// File: bench/indexed_ring_deque_tb.sv
`timescale 1ns / 1ps
module indexed_ring_deque_tb;

    localparam int RING_DEPTH = 64;
    localparam int IDLE_LIMIT = 20000;

    // Shadow ring that computes the expected result of each item
    class deque_scoreboard;
        logic [31:0] words[RING_DEPTH];
        int unsigned head;
        int unsigned count;
        ird_pkg::out_item_t pending[$];
        int errors;

        function new();
            head = 0;
            count = 0;
            errors = 0;
        endfunction

        function int unsigned slot(int unsigned k);
            return (head + k) % RING_DEPTH;
        endfunction

        function void put_at(int unsigned idx, logic [31:0] w);
            for (int unsigned k = count; k > idx; k--)
                words[slot(k)] = words[slot(k - 1)];
            words[slot(idx)] = w;
            count++;
        endfunction

        function logic [31:0] take_at(int unsigned idx);
            logic [31:0] w;
            w = words[slot(idx)];
            for (int unsigned k = idx; k + 1 < count; k++)
                words[slot(k)] = words[slot(k + 1)];
            count--;
            if (count == 0)
                head = 0;
            return w;
        endfunction

        // Apply one accepted item and queue its expected result
        function void note_item(ird_pkg::in_item_t it);
            int p;
            int len;
            ird_pkg::out_item_t r;
            p = $signed(it.position);
            len = count;
            r.result_value = '0;
            r.status = ird_pkg::ST_OK;
            case (it.action) inside
                ird_pkg::ACT_GET, ird_pkg::ACT_PUT:
                    if (p < 0 || p >= len)
                        r.status = ird_pkg::ST_RANGE;
                    else
                    begin
                        r.result_value = words[slot(p)];
                        if (it.action == ird_pkg::ACT_PUT)
                            words[slot(p)] = it.value;
                    end
                ird_pkg::ACT_INSERT:
                    if (p < -len || p > len + 1)
                        r.status = ird_pkg::ST_RANGE;
                    else if (count >= RING_DEPTH)
                        r.status = ird_pkg::ST_FULL;
                    else
                    begin
                        put_at((p >= 1) ? p - 1 : p + len, it.value);
                        r.result_value = it.value;
                    end
                ird_pkg::ACT_ADD_LOW, ird_pkg::ACT_ADD_HIGH:
                    if (count >= RING_DEPTH)
                        r.status = ird_pkg::ST_FULL;
                    else
                    begin
                        put_at(it.action == ird_pkg::ACT_ADD_LOW ? 0 : count, it.value);
                        r.result_value = it.value;
                    end
                ird_pkg::ACT_REMOVE:
                    if (len == 0)
                        r.status = ird_pkg::ST_EMPTY;
                    else if (p < 0 || p >= len)
                        r.status = ird_pkg::ST_RANGE;
                    else
                        r.result_value = take_at(p);
                ird_pkg::ACT_REMOVE_LOW, ird_pkg::ACT_REMOVE_HIGH:
                    if (len == 0)
                        r.status = ird_pkg::ST_EMPTY;
                    else
                        r.result_value =
                            take_at(it.action == ird_pkg::ACT_REMOVE_LOW ? 0 : count - 1);
                ird_pkg::ACT_ROTATE:
                    if (len != 0)
                    begin
                        if (p < -len || p > len)
                            r.status = ird_pkg::ST_RANGE;
                        else
                            head = slot((p >= 0) ? p % len : p + len);
                    end
                default:
                begin
                end
            endcase
            r.fill_level = 7'(count);
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
        endtask

        task check_result(ird_pkg::out_item_t got);
            ird_pkg::out_item_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", 0, got);
                return;
            end
            want = pending.pop_front();
            if (got.result_value !== want.result_value)
                report_mismatch("result_value", want.result_value, got.result_value);
            if (got.fill_level !== want.fill_level)
                report_mismatch("fill_level", want.fill_level, got.fill_level);
            if (got.status !== want.status)
                report_mismatch("status", want.status, got.status);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    ird_pkg::in_item_t in_data;
    logic out_valid;
    logic out_ready = 1'b0;
    ird_pkg::out_item_t out_data;

    deque_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles = 0;

    indexed_ring_deque u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Check results and toggle receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one item and hold it until accepted
    task automatic send_item(logic [3:0] act, logic signed [7:0] pos, logic [31:0] val);
        ird_pkg::in_item_t it;
        it.action = act;
        it.position = pos;
        it.value = val;
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(it);
        in_valid <= 1'b0;
        // The block is busy after an accept anyway
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Mostly valid positions, some out of range
    function automatic logic signed [7:0] pick_position(int len);
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return 8'($signed($urandom_range(2 * len + 2)) - len);
        else if (r < 90)
            return 8'($urandom_range(255));
        else
            return (r & 1) ? 8'sd127 : 8'sh80;
    endfunction

    task automatic random_phase(int n, int fill_bias);
        int r;
        logic [3:0] act;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 2)
                act = 4'($urandom_range(15, 9));
            else if (r < fill_bias)
                act = (r & 1) ? ird_pkg::ACT_ADD_HIGH : ird_pkg::ACT_ADD_LOW;
            else
                act = 4'($urandom_range(8));
            send_item(act, pick_position(sb.count), $urandom);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-ring errors, ends, inserts, rotate, extremes
        send_item(ird_pkg::ACT_REMOVE, 0, 0);
        send_item(ird_pkg::ACT_REMOVE_LOW, 0, 0);
        send_item(ird_pkg::ACT_REMOVE_HIGH, 0, 0);
        send_item(ird_pkg::ACT_GET, 0, 0);
        send_item(ird_pkg::ACT_PUT, 0, 32'hFFFF_FFFF);
        send_item(ird_pkg::ACT_ROTATE, 8'sd127, 0);
        send_item(ird_pkg::ACT_INSERT, 8'sd2, 32'h1);
        send_item(ird_pkg::ACT_INSERT, 8'sd1, 32'hFFFF_FFFF);
        send_item(ird_pkg::ACT_INSERT, 8'sd0, 32'h0);
        send_item(ird_pkg::ACT_INSERT, -8'sd3, 32'hA5A5_5A5A);
        send_item(ird_pkg::ACT_INSERT, 8'sd5, 32'h5A5A_A5A5);
        send_item(ird_pkg::ACT_INSERT, 8'sh80, 32'h1234_5678);
        send_item(ird_pkg::ACT_ADD_LOW, 0, 32'h8000_0000);
        send_item(ird_pkg::ACT_ADD_HIGH, 0, 32'h0000_0001);
        send_item(ird_pkg::ACT_GET, 8'sd5, 0);
        send_item(ird_pkg::ACT_GET, -8'sd1, 0);
        send_item(ird_pkg::ACT_PUT, 8'sd2, 32'hDEAD_BEEF);
        send_item(ird_pkg::ACT_ROTATE, -8'sd6, 0);
        send_item(ird_pkg::ACT_ROTATE, 8'sd4, 0);
        send_item(ird_pkg::ACT_ROTATE, -8'sd7, 0);
        send_item(ird_pkg::ACT_REMOVE, 8'sd6, 0);
        send_item(ird_pkg::ACT_REMOVE, 8'sd2, 0);
        send_item(4'hF, 8'sd1, 32'hFFFF_FFFF);
        // Fill to full, then hit the full checks
        while (sb.count < RING_DEPTH)
            send_item(ird_pkg::ACT_ADD_HIGH, 0, $urandom);
        send_item(ird_pkg::ACT_ADD_LOW, 0, 1);
        send_item(ird_pkg::ACT_INSERT, 8'sd65, 2);
        send_item(ird_pkg::ACT_INSERT, 8'sd66, 3);
        send_item(ird_pkg::ACT_ROTATE, 8'sd64, 0);
        send_item(ird_pkg::ACT_REMOVE, 8'sd0, 0);
        send_item(ird_pkg::ACT_REMOVE, 8'sd62, 0);

        // Hold off the sender until the ring has answered everything
        drain();

        random_phase(175, 30);
        send_idle_pct = 45;
        random_phase(175, 20);
        send_idle_pct = 0;
        recv_stall_pct = 45;
        random_phase(175, 45);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        random_phase(175, 10);
        recv_stall_pct = 0;

        drain();
        repeat (80) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
